// ===== src/chhc_pkg.sv =====
// Shared types, constants and helper functions for the chained hash colour histogram.
`timescale 1ns / 1ps
package chhc_pkg;

  localparam int BIN_ADDR_BITS = 14;
  localparam int NUM_BINS      = 1 << BIN_ADDR_BITS;
  localparam int ENTRY_DEPTH   = 4096;
  localparam int ENTRY_W       = $clog2(ENTRY_DEPTH);
  localparam int BIN_W         = BIN_ADDR_BITS;
  localparam int HASH_W        = 16;
  localparam int COLOR_W       = 32;
  localparam int WEIGHT_W      = 14;
  localparam int IDX_W         = 12;
  localparam int STATUS_W      = 3;

  localparam logic [WEIGHT_W-1:0] COUNT_MAX = WEIGHT_W'(10000);

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_SPARE = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_EXISTING = 3'd0,
    ST_NEW      = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_CLEARED  = 3'd3,
    ST_READ     = 3'd4
  } status_code_t;

  // controller -> datapath
  typedef struct packed {
    logic         load;
    logic         head_rd;
    logic         walk_head;
    logic         walk_next;
    logic         tail_upd;
    logic         freq_wr;
    logic         ins_wr;
    logic         link_wr;
    logic         clr;
    logic         set_full;
    logic         entry_rd;
    logic         finish;
    status_code_t code;
  } chhc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic head_ok;
    logic first;
    logic hash_ok;
    logic match;
    logic next_zero;
    logic at_cap;
    logic full;
  } chhc_stat_t;

  function automatic logic [BIN_W-1:0] bin_of(input logic [COLOR_W-1:0] rgba);
    logic [HASH_W-1:0] h;
    h = (HASH_W'(rgba[7:0]) << 6) | (HASH_W'(rgba[15:8]) << 4) |
        (HASH_W'(rgba[23:16]) << 2) | HASH_W'(rgba[31:24]);
    return h[BIN_W-1:0];
  endfunction

  function automatic logic [WEIGHT_W-1:0] sat_add(input logic [WEIGHT_W-1:0] base,
                                                  input logic [WEIGHT_W-1:0] w);
    logic [WEIGHT_W:0] s;
    s = {1'b0, base} + {1'b0, w};
    return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[WEIGHT_W-1:0];
  endfunction

endpackage

// ===== src/color_histogram_hash_chain_top.sv =====
// Top level of the chained hash colour histogram.
`timescale 1ns / 1ps
// Start a transaction by raising start while busy is low; exactly one result follows,
// shown for one cycle with done high, and it cannot be held off. Clear, and an add while
// the store is flagged full, finish in the accepting cycle (done on the next). A read
// passes the read-wait state before it finishes. An add reads the bin head, walks its
// chain comparing colours, and on a match updates the count; a colour new to the bin is
// inserted, then linked behind the old tail (dropped if the store is at capacity). A stale
// bin head pointing into the store is caught at the first node and the add goes to insert.
// The chain walk visits one node per cycle, bounded by the registered reads of the link
// and entry stores. Table state after clear needs no sweep; bin heads are checked against
// the entry total and the hash of their entry, so the block is ready straight after reset.
module color_histogram_hash_chain_top import chhc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  input  logic [1:0]          action,
  input  logic [COLOR_W-1:0]  pixel_word,
  input  logic [WEIGHT_W-1:0] pixel_weight,
  input  logic [IDX_W-1:0]    entry_index,
  input  logic                last_in_batch,
  output logic [STATUS_W-1:0] status,
  output logic                table_full,
  output logic [IDX_W-1:0]    distinct_count,
  output logic [COLOR_W-1:0]  entry_color,
  output logic [WEIGHT_W-1:0] entry_count,
  output logic                batch_end
);

  chhc_cmd_t  cmd;
  chhc_stat_t stat;

  chhc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  chhc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .pixel_word     (pixel_word),
    .pixel_weight   (pixel_weight),
    .entry_index    (entry_index),
    .last_in_batch  (last_in_batch),
    .status         (status),
    .table_full     (table_full),
    .distinct_count (distinct_count),
    .entry_color    (entry_color),
    .entry_count    (entry_count),
    .batch_end      (batch_end)
  );

endmodule

// ===== src/chhc_ctrl.sv =====
// Controller state machine: sequences head lookup, chain walk, insert, clear and read-back.
`timescale 1ns / 1ps
module chhc_ctrl import chhc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] action,
  input  chhc_stat_t stat,
  output chhc_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HEAD = 6'b000010,
    S_CMP  = 6'b000100,
    S_INS  = 6'b001000,
    S_LINK = 6'b010000,
    S_RDW  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (action_t'(action))
            ACT_ADD: begin
              if (stat.full) begin
                cmd.finish = 1'b1;
                cmd.code   = ST_DROPPED;
              end else begin
                cmd.head_rd = 1'b1;
                state_next  = S_HEAD;
              end
            end
            ACT_CLEAR: begin
              cmd.clr    = 1'b1;
              cmd.finish = 1'b1;
              cmd.code   = ST_CLEARED;
            end
            default: begin
              cmd.entry_rd = 1'b1;
              state_next   = S_RDW;
            end
          endcase
        end
      end
      S_HEAD: begin
        if (stat.head_ok) begin
          cmd.walk_head = 1'b1;
          state_next    = S_CMP;
        end else begin
          state_next = S_INS;
        end
      end
      S_CMP: begin
        // a stale head left from before a clear points at an entry of another bin
        if (stat.first && !stat.hash_ok) begin
          state_next = S_INS;
        end else if (stat.match) begin
          cmd.freq_wr = 1'b1;
          cmd.finish  = 1'b1;
          cmd.code    = ST_EXISTING;
          state_next  = S_IDLE;
        end else begin
          cmd.tail_upd = 1'b1;
          if (stat.next_zero) begin
            state_next = S_INS;
          end else begin
            cmd.walk_next = 1'b1;
          end
        end
      end
      S_INS: begin
        if (stat.at_cap) begin
          cmd.set_full = 1'b1;
          cmd.finish   = 1'b1;
          cmd.code     = ST_DROPPED;
          state_next   = S_IDLE;
        end else begin
          cmd.ins_wr = 1'b1;
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        cmd.link_wr = 1'b1;
        cmd.finish  = 1'b1;
        cmd.code    = ST_NEW;
        state_next  = S_IDLE;
      end
      S_RDW: begin
        cmd.finish = 1'b1;
        cmd.code   = ST_READ;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !busy)
    else $error("controller not idle after finishing a transaction");

  a_clear_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_CLEAR) |=> done)
    else $error("clear transaction did not complete in one cycle");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state not one-hot");

endmodule

// ===== src/chhc_datapath.sv =====
// Datapath: bin head, chain link and entry stores, totals and result registers.
`timescale 1ns / 1ps
module chhc_datapath import chhc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  chhc_cmd_t           cmd,
  output chhc_stat_t          stat,
  input  logic [COLOR_W-1:0]  pixel_word,
  input  logic [WEIGHT_W-1:0] pixel_weight,
  input  logic [IDX_W-1:0]    entry_index,
  input  logic                last_in_batch,
  output logic [STATUS_W-1:0] status,
  output logic                table_full,
  output logic [IDX_W-1:0]    distinct_count,
  output logic [COLOR_W-1:0]  entry_color,
  output logic [WEIGHT_W-1:0] entry_count,
  output logic                batch_end
);

  // stores; node number = entry number + 1, zero ends a chain
  logic [ENTRY_W-1:0]  bin_head_mem [NUM_BINS];
  logic [ENTRY_W-1:0]  chain_mem    [ENTRY_DEPTH];
  logic [COLOR_W-1:0]  rgba_mem     [ENTRY_DEPTH];
  logic [WEIGHT_W-1:0] freq_mem     [ENTRY_DEPTH];

  logic [ENTRY_W-1:0]  head_q, next_q;
  logic [COLOR_W-1:0]  rgba_q;
  logic [WEIGHT_W-1:0] freq_q;

  logic [COLOR_W-1:0]  pix;
  logic [WEIGHT_W-1:0] weight;
  logic [BIN_W-1:0]    bin;
  logic [ENTRY_W-1:0]  cur, tail, total;
  logic                first, rd_ok, full, last_r;
  status_code_t        res_code;
  logic [COLOR_W-1:0]  res_color;
  logic [WEIGHT_W-1:0] res_count;

  logic [ENTRY_W-1:0]  node_sel, ent_rd_addr, chain_wr_addr, chain_wr_data, new_node;
  logic                ent_rd_en, chain_rd_en, chain_wr_en;

  assign new_node    = total + ENTRY_W'(1);
  assign node_sel    = cmd.walk_head ? head_q : next_q;
  assign ent_rd_addr = cmd.entry_rd ? ENTRY_W'(entry_index) : (node_sel - ENTRY_W'(1));
  assign ent_rd_en   = cmd.entry_rd | cmd.walk_head | cmd.walk_next;
  assign chain_rd_en = cmd.walk_head | cmd.walk_next;

  // new node gets a terminated link; the old tail is linked in the next cycle
  assign chain_wr_en   = cmd.ins_wr | (cmd.link_wr && tail != '0);
  assign chain_wr_addr = cmd.ins_wr ? new_node : tail;
  assign chain_wr_data = cmd.ins_wr ? '0 : new_node;

  always_ff @(posedge clk) begin
    if (cmd.head_rd) begin
      head_q <= bin_head_mem[bin_of(pixel_word)];
    end
    if (cmd.ins_wr && tail == '0) begin
      bin_head_mem[bin] <= new_node;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_rd_en) begin
      next_q <= chain_mem[node_sel];
    end
    if (chain_wr_en) begin
      chain_mem[chain_wr_addr] <= chain_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_rd_en) begin
      rgba_q <= rgba_mem[ent_rd_addr];
      freq_q <= freq_mem[ent_rd_addr];
    end
    if (cmd.ins_wr) begin
      rgba_mem[total] <= pix;
    end
    if (cmd.ins_wr) begin
      freq_mem[total] <= sat_add('0, weight);
    end else if (cmd.freq_wr) begin
      freq_mem[cur - ENTRY_W'(1)] <= sat_add(freq_q, weight);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      full  <= 1'b0;
    end else begin
      if (cmd.clr) begin
        total <= '0;
        full  <= 1'b0;
      end else begin
        if (cmd.link_wr) total <= new_node;
        if (cmd.set_full) full <= 1'b1;
      end
    end
  end

  // transaction payload and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix    <= pixel_word;
      weight <= pixel_weight;
      bin    <= bin_of(pixel_word);
      last_r <= last_in_batch;
      tail   <= '0;
    end
    if (cmd.entry_rd) begin
      rd_ok <= (ENTRY_W'(entry_index) < total);
    end
    if (cmd.walk_head || cmd.walk_next) begin
      cur   <= node_sel;
      first <= cmd.walk_head;
    end
    if (cmd.tail_upd) begin
      tail <= cur;
    end
    if (cmd.finish) begin
      res_code  <= cmd.code;
      res_color <= (cmd.code == ST_READ && rd_ok) ? rgba_q : '0;
      res_count <= (cmd.code == ST_READ && rd_ok) ? freq_q : '0;
    end
  end

  always_comb begin
    stat.head_ok   = (head_q != '0) && (head_q <= total);
    stat.first     = first;
    stat.hash_ok   = (bin_of(rgba_q) == bin);
    stat.match     = (rgba_q == pix);
    stat.next_zero = (next_q == '0);
    stat.at_cap    = (total >= ENTRY_W'(ENTRY_DEPTH - 1));
    stat.full      = full;
  end

  assign status         = res_code;
  assign table_full     = full;
  assign distinct_count = IDX_W'(total);
  assign entry_color    = res_color;
  assign entry_count    = res_count;
  assign batch_end      = last_r;

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= ENTRY_W'(ENTRY_DEPTH - 1))
    else $error("entry total beyond store capacity");

  a_full_at_cap: assert property (@(posedge clk) disable iff (rst)
    full |-> (total == ENTRY_W'(ENTRY_DEPTH - 1)))
    else $error("full flag set while store has room");

  a_link_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.link_wr && !cmd.clr) |=> (total == $past(total) + ENTRY_W'(1)))
    else $error("new entry not counted");

endmodule
